### hw/rtl/handheld_timer_divider_macros.svh
// assertion helpers for the timer and divider block
`ifndef HANDHELD_TIMER_DIVIDER_MACROS_SVH
`define HANDHELD_TIMER_DIVIDER_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define HTD_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define HTD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/htd_pkg.sv
package htd_pkg;

    localparam int PRE_W = 18;
    localparam int CNT_W = 8;
    localparam int PER_W = 16;
    localparam int ELAPSED_W = 7;
    localparam int CFG_IDX_W = 3;

    localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

    // command codes
    localparam logic [1:0] CMD_ADVANCE       = 2'd0;
    localparam logic [1:0] CMD_RESTART_DIV   = 2'd1;
    localparam logic [1:0] CMD_RESTART_TIMER = 2'd2;

    // rate select codes
    localparam logic [1:0] RATE_ZERO  = 2'd0;
    localparam logic [1:0] RATE_ONE   = 2'd1;
    localparam logic [1:0] RATE_TWO   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TIMER_ENABLE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_SELECT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RELOAD_VALUE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_ZERO    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_ONE     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_TWO     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_THREE   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DIVIDER_PERIOD = 3'd7;

    // reset values
    localparam logic [PER_W-1:0] RST_PERIOD_ZERO    = 16'd1024;
    localparam logic [PER_W-1:0] RST_PERIOD_ONE     = 16'd16;
    localparam logic [PER_W-1:0] RST_PERIOD_TWO     = 16'd64;
    localparam logic [PER_W-1:0] RST_PERIOD_THREE   = 16'd256;
    localparam logic [PER_W-1:0] RST_DIVIDER_PERIOD = 16'd256;
    localparam logic [PRE_W-1:0] RST_TIMER_PRE      = 18'd1024;
    localparam logic [PRE_W-1:0] RST_DIV_PRE        = 18'd256;

    // lower bounds on the periods
    localparam logic [PER_W-1:0] MIN_TIMER_PERIOD   = 16'd16;
    localparam logic [PER_W-1:0] MIN_DIVIDER_PERIOD = 16'd64;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_T_SUB,
        ST_T_LOOP,
        ST_D_SUB,
        ST_D_FIX,
        ST_DONE
    } state_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        logic [PRE_W-1:0] sum;
        logic             a_nonpos;
    } alu_res_t;

    typedef struct packed {
        logic             timer_enable;
        logic [CNT_W-1:0] reload_value;
        logic [PER_W-1:0] timer_period;
        logic [PER_W-1:0] divider_period;
    } cfg_t;

endpackage

### hw/rtl/htd_alu.sv
// shared 18-bit add/subtract unit with a not-positive test on operand a
module htd_alu
(
    input  htd_pkg::alu_op_t              op,
    input  logic [htd_pkg::PRE_W-1:0]     a,
    input  logic [htd_pkg::PRE_W-1:0]     b,
    output htd_pkg::alu_res_t             res
);

    always_comb
    begin
        case (op)
            htd_pkg::ALU_SUB: res.sum = a - b;
            default:          res.sum = a + b;
        endcase
        res.a_nonpos = a[htd_pkg::PRE_W-1] | (a == '0);
    end

endmodule

### hw/rtl/htd_cfg.sv
// configuration registers, period select and lower-bound clamp
module htd_cfg
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [htd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [htd_pkg::PER_W-1:0]         cfg_data,
    output htd_pkg::cfg_t                     cfg
);

    logic                          timer_enable_reg;
    logic [1:0]                    rate_select_reg;
    logic [htd_pkg::CNT_W-1:0]     reload_value_reg;
    logic [htd_pkg::PER_W-1:0]     period_zero_reg;
    logic [htd_pkg::PER_W-1:0]     period_one_reg;
    logic [htd_pkg::PER_W-1:0]     period_two_reg;
    logic [htd_pkg::PER_W-1:0]     period_three_reg;
    logic [htd_pkg::PER_W-1:0]     divider_period_reg;
    logic [htd_pkg::PER_W-1:0]     sel_period;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timer_enable_reg   <= 1'b0;
            rate_select_reg    <= 2'd0;
            reload_value_reg   <= '0;
            period_zero_reg    <= htd_pkg::RST_PERIOD_ZERO;
            period_one_reg     <= htd_pkg::RST_PERIOD_ONE;
            period_two_reg     <= htd_pkg::RST_PERIOD_TWO;
            period_three_reg   <= htd_pkg::RST_PERIOD_THREE;
            divider_period_reg <= htd_pkg::RST_DIVIDER_PERIOD;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                htd_pkg::REG_TIMER_ENABLE:   timer_enable_reg   <= cfg_data[0];
                htd_pkg::REG_RATE_SELECT:    rate_select_reg    <= cfg_data[1:0];
                htd_pkg::REG_RELOAD_VALUE:   reload_value_reg   <= cfg_data[7:0];
                htd_pkg::REG_PERIOD_ZERO:    period_zero_reg    <= cfg_data;
                htd_pkg::REG_PERIOD_ONE:     period_one_reg     <= cfg_data;
                htd_pkg::REG_PERIOD_TWO:     period_two_reg     <= cfg_data;
                htd_pkg::REG_PERIOD_THREE:   period_three_reg   <= cfg_data;
                htd_pkg::REG_DIVIDER_PERIOD: divider_period_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (rate_select_reg)
            htd_pkg::RATE_ZERO: sel_period = period_zero_reg;
            htd_pkg::RATE_ONE:  sel_period = period_one_reg;
            htd_pkg::RATE_TWO:  sel_period = period_two_reg;
            default:            sel_period = period_three_reg;
        endcase

        cfg.timer_enable = timer_enable_reg;
        cfg.reload_value = reload_value_reg;
        cfg.timer_period = (sel_period < htd_pkg::MIN_TIMER_PERIOD)
                         ? htd_pkg::MIN_TIMER_PERIOD : sel_period;
        cfg.divider_period = (divider_period_reg < htd_pkg::MIN_DIVIDER_PERIOD)
                           ? htd_pkg::MIN_DIVIDER_PERIOD : divider_period_reg;
    end

endmodule

### hw/rtl/handheld_timer_divider.sv
// handheld timer and divider: each input transfer carries a command (advance by a
// number of elapsed machine cycles, restart the divider prescaler, or restart the
// timer prescaler) and yields exactly one output transfer with the timer count,
// the divider value and an interrupt flag set when the timer overflowed during that
// step. one shared 18-bit adder, stepped by a small sequencer, does all prescaler
// arithmetic: an advance with the timer enabled subtracts the elapsed cycles, adds the
// timer period back once per expiry (at most 8 per step, since timer periods are
// clamped to at least 16), then updates the divider; with the timer disabled only the
// divider is updated, and a restart or unused command goes straight to the result.
// the input is not ready while a step is in progress; a finished result sits in an
// output register, so the next input is taken while it waits. configuration writes
// are taken at any time but should only be issued while the block is idle.
module handheld_timer_divider
(
    input  logic        clk,
    input  logic        rst_n,

    // configuration write port
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data,

    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [1:0] command, [8:2] elapsed_cycles, rest zero

    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata     // [7:0] timer_count, [15:8] divider_value,
                                    // [16] timer_interrupt, rest zero
);

`include "handheld_timer_divider_macros.svh"

    htd_pkg::cfg_t                       cfg;
    htd_pkg::alu_op_t                    alu_op;
    htd_pkg::alu_res_t                   alu_res;
    logic [htd_pkg::PRE_W-1:0]           alu_a;
    logic [htd_pkg::PRE_W-1:0]           alu_b;

    // sequencer and working state
    htd_pkg::state_t                     state_reg, state_next;
    logic [htd_pkg::PRE_W-1:0]           tpre_reg, tpre_next;
    logic [htd_pkg::PRE_W-1:0]           dpre_reg, dpre_next;
    logic [htd_pkg::CNT_W-1:0]           tcnt_reg, tcnt_next;
    logic [htd_pkg::CNT_W-1:0]           dcnt_reg, dcnt_next;
    logic                                irq_reg, irq_next;
    logic [htd_pkg::ELAPSED_W-1:0]       elapsed_reg, elapsed_next;

    // output register
    logic                                out_valid_reg, out_valid_next;
    logic [htd_pkg::CNT_W-1:0]           out_tcnt_reg, out_tcnt_next;
    logic [htd_pkg::CNT_W-1:0]           out_dcnt_reg, out_dcnt_next;
    logic                                out_irq_reg, out_irq_next;

    // widened operands for the shared adder
    logic [htd_pkg::PRE_W-1:0]           tper_ext;
    logic [htd_pkg::PRE_W-1:0]           dper_ext;
    logic [htd_pkg::PRE_W-1:0]           elapsed_ext;
    logic [1:0]                          in_command;

    // timer prescaler expired, taken straight from the register so the
    // loop decision does not depend on which operand the adder is given
    logic                                tpre_nonpos;

    htd_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    htd_alu u_alu
    (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    assign tper_ext    = {2'b00, cfg.timer_period};
    assign dper_ext    = {2'b00, cfg.divider_period};
    assign elapsed_ext = {{(htd_pkg::PRE_W-htd_pkg::ELAPSED_W){1'b0}}, elapsed_reg};
    assign in_command  = s_tdata[1:0];
    assign tpre_nonpos = tpre_reg[htd_pkg::PRE_W-1] | (tpre_reg == '0);

    assign s_tready = (state_reg == htd_pkg::ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_irq_reg, out_dcnt_reg, out_tcnt_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= htd_pkg::ST_IDLE;
            tpre_reg      <= htd_pkg::RST_TIMER_PRE;
            dpre_reg      <= htd_pkg::RST_DIV_PRE;
            tcnt_reg      <= '0;
            dcnt_reg      <= '0;
            irq_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tpre_reg      <= tpre_next;
            dpre_reg      <= dpre_next;
            tcnt_reg      <= tcnt_next;
            dcnt_reg      <= dcnt_next;
            irq_reg       <= irq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        elapsed_reg  <= elapsed_next;
        out_tcnt_reg <= out_tcnt_next;
        out_dcnt_reg <= out_dcnt_next;
        out_irq_reg  <= out_irq_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        tpre_next      = tpre_reg;
        dpre_next      = dpre_reg;
        tcnt_next      = tcnt_reg;
        dcnt_next      = dcnt_reg;
        irq_next       = irq_reg;
        elapsed_next   = elapsed_reg;
        out_tcnt_next  = out_tcnt_reg;
        out_dcnt_next  = out_dcnt_reg;
        out_irq_next   = out_irq_reg;
        out_valid_next = out_valid_reg;

        // default adder use: timer prescaler plus its period
        alu_op = htd_pkg::ALU_ADD;
        alu_a  = tpre_reg;
        alu_b  = tper_ext;

        // result taken downstream
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            htd_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    elapsed_next = s_tdata[8:2];
                    irq_next     = 1'b0;
                    case (in_command)
                        htd_pkg::CMD_ADVANCE:
                        begin
                            state_next = cfg.timer_enable ? htd_pkg::ST_T_SUB
                                                          : htd_pkg::ST_D_SUB;
                        end
                        htd_pkg::CMD_RESTART_DIV:
                        begin
                            dpre_next  = dper_ext;
                            state_next = htd_pkg::ST_DONE;
                        end
                        htd_pkg::CMD_RESTART_TIMER:
                        begin
                            tpre_next  = tper_ext;
                            state_next = htd_pkg::ST_DONE;
                        end
                        default:
                        begin
                            // unused command: state untouched, current values out
                            state_next = htd_pkg::ST_DONE;
                        end
                    endcase
                end
            end

            htd_pkg::ST_T_SUB:
            begin
                alu_op     = htd_pkg::ALU_SUB;
                alu_b      = elapsed_ext;
                tpre_next  = alu_res.sum;
                state_next = htd_pkg::ST_T_LOOP;
            end

            htd_pkg::ST_T_LOOP:
            begin
                if (tpre_nonpos)
                begin
                    // one expiry: add the period back and bump the count
                    tpre_next = alu_res.sum;
                    if (tcnt_reg == htd_pkg::CNT_MAX)
                    begin
                        tcnt_next = cfg.reload_value;
                        irq_next  = 1'b1;
                    end
                    else
                    begin
                        tcnt_next = tcnt_reg + 8'd1;
                    end
                end
                else
                begin
                    // timer settled, adder moves on to the divider prescaler
                    alu_op     = htd_pkg::ALU_SUB;
                    alu_a      = dpre_reg;
                    alu_b      = elapsed_ext;
                    dpre_next  = alu_res.sum;
                    state_next = htd_pkg::ST_D_FIX;
                end
            end

            htd_pkg::ST_D_SUB:
            begin
                alu_op     = htd_pkg::ALU_SUB;
                alu_a      = dpre_reg;
                alu_b      = elapsed_ext;
                dpre_next  = alu_res.sum;
                state_next = htd_pkg::ST_D_FIX;
            end

            htd_pkg::ST_D_FIX:
            begin
                // divider advances at most once a step
                alu_a = dpre_reg;
                alu_b = dper_ext;
                if (alu_res.a_nonpos)
                begin
                    dpre_next = alu_res.sum;
                    dcnt_next = dcnt_reg + 8'd1;
                end
                state_next = htd_pkg::ST_DONE;
            end

            htd_pkg::ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_tcnt_next  = tcnt_reg;
                    out_dcnt_next  = dcnt_reg;
                    out_irq_next   = irq_reg;
                    out_valid_next = 1'b1;
                    state_next     = htd_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = htd_pkg::ST_IDLE;
            end
        endcase
    end

    // an accepted transfer always starts a step
    `HTD_ASSERT_NEXT(a_accept_starts, s_tvalid && s_tready, state_reg != htd_pkg::ST_IDLE, "accepted transfer did not start a step")

    // between steps the timer prescaler is strictly positive
    `HTD_ASSERT_SAME(a_tpre_positive, state_reg == htd_pkg::ST_IDLE, !tpre_reg[htd_pkg::PRE_W-1] && (tpre_reg != '0), "timer prescaler not positive while idle")

    // once the timer prescaler is positive the loop hands over to the divider
    `HTD_ASSERT_NEXT(a_loop_exit, (state_reg == htd_pkg::ST_T_LOOP) && !tpre_nonpos, state_reg == htd_pkg::ST_D_FIX, "timer loop did not hand over to the divider")

endmodule
